// File: rtl/core/wle_pkg.sv
// Shared types, register codes and constants of the welding light effect.
`timescale 1ns / 1ps

package wle_pkg;

	localparam int unsigned TIME_BITS_DEF = 16;

	localparam int unsigned NUM_REGS  = 3;
	localparam int unsigned CFG_IDX_W = $clog2(NUM_REGS);
	localparam int unsigned CFG_ADDR_W = CFG_IDX_W + 2;

	localparam logic [CFG_IDX_W-1:0] REG_GLOW_START   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_GLOW_STEP_MS = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_POLL_MS = CFG_IDX_W'(2);

	localparam logic [5:0] GLOW_START_RST   = 6'd12;
	localparam logic [7:0] GLOW_STEP_MS_RST = 8'd50;
	localparam logic [7:0] IDLE_POLL_MS_RST = 8'd100;

	localparam int unsigned FLICK_MIN = 100;
	localparam int unsigned FLICK_MAX = 255;
	localparam int unsigned DELAY_MIN = 15;
	localparam int unsigned DELAY_MAX = 125;
	localparam int unsigned COUNT_MIN = 50;
	localparam int unsigned COUNT_MAX = 150;
	localparam int unsigned PAUSE_MIN = 1000;
	localparam int unsigned PAUSE_MAX = 4000;
	localparam int unsigned SUB_BLUE  = 50;

	localparam logic [7:0]  FLICK_SPAN = 8'(FLICK_MAX - FLICK_MIN);
	localparam logic [7:0]  DELAY_SPAN = 8'(DELAY_MAX - DELAY_MIN);
	localparam logic [7:0]  COUNT_SPAN = 8'(COUNT_MAX - COUNT_MIN);
	localparam logic [11:0] PAUSE_SPAN = 12'(PAUSE_MAX - PAUSE_MIN);

	typedef struct packed {
		logic [15:0] now_ms;
		logic        enable;
		logic [7:0]  rand_level;
		logic [7:0]  rand_delay;
		logic [15:0] rand_pause;
	} wle_in_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       stepped;
	} wle_out_t;

endpackage

// File: rtl/core/wle_ifs.sv
// Valid/ready channel interfaces for the input calls and the LED results.
`timescale 1ns / 1ps

interface wle_in_if;
	logic             valid;
	logic             ready;
	wle_pkg::wle_in_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface wle_out_if;
	logic              valid;
	logic              ready;
	wle_pkg::wle_out_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/welding_light_effect.sv
// Welding arc light effect for one RGB LED: timer check, phase step and LED output.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------------------
//  sample  | in        | valid/ready         | now_ms, enable, rand_level, rand_delay, rand_pause
//  led     | out       | valid/ready         | red, green, blue, stepped
//  apb     | in        | psel/penable/pready | paddr, pwdata, prdata (3 registers)
//
// Each transaction is registered in the input stage, stepped combinationally and then loaded
// into the result register; while led is not stalled a new transaction is taken every cycle,
// so throughput is one per clock. A result is valid once loaded and is held until led takes it.
// The phase state updates as the result register loads, so the next call sees it at once.
// Reset (arst_n low) clears both stages and all effect state and reloads register defaults.
// A stall on led holds the result; sample keeps flowing until both stages are full.
`timescale 1ns / 1ps

module welding_light_effect #(
	parameter int unsigned TIME_BITS = wle_pkg::TIME_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	wle_in_if.sink                          sample,
	wle_out_if.source                       led,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [wle_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import wle_pkg::*;

	localparam int unsigned CW = (TIME_BITS > 16) ? TIME_BITS : 16;

	// Configuration registers.
	logic [5:0] glow_start_q;
	logic [7:0] glow_step_ms_q;
	logic [7:0] idle_poll_ms_q;

	logic [CFG_IDX_W-1:0] cfg_idx;
	logic                 cfg_wr;

	// Effect state.
	logic [TIME_BITS-1:0] last_q;
	logic [15:0]          wait_q;
	logic [7:0]           flickers_q;
	logic [7:0]           red_q;
	logic [7:0]           green_q;
	logic [7:0]           blue_q;

	// Pipeline.
	logic     valid_s1;
	wle_in_t  data_s1;
	logic     res_valid_q;
	wle_out_t res_q;
	logic     adv;

	// Step logic.
	logic [CW-1:0]        now_ext;
	logic [TIME_BITS-1:0] now_tb;
	logic [TIME_BITS-1:0] elapsed;
	logic                 expired;
	logic [15:0]          prod_level;
	logic [15:0]          prod_delay;
	logic [15:0]          prod_count;
	logic [27:0]          prod_pause;
	logic [7:0]           flick_lvl;
	logic [7:0]           white_lvl;
	logic [7:0]           delay_ms;
	logic [7:0]           count_val;
	logic [15:0]          pause_ms;
	logic [7:0]           flick_dec;
	logic [7:0]           green_dec;

	logic [15:0] wait_d;
	logic [7:0]  flickers_d;
	logic [7:0]  red_d;
	logic [7:0]  green_d;
	logic [7:0]  blue_d;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[CFG_ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		case (cfg_idx)
			REG_GLOW_START:   prdata = 32'(glow_start_q);
			REG_GLOW_STEP_MS: prdata = 32'(glow_step_ms_q);
			REG_IDLE_POLL_MS: prdata = 32'(idle_poll_ms_q);
			default:          prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glow_start_q   <= GLOW_START_RST;
			glow_step_ms_q <= GLOW_STEP_MS_RST;
			idle_poll_ms_q <= IDLE_POLL_MS_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_GLOW_START:   glow_start_q   <= pwdata[5:0];
				REG_GLOW_STEP_MS: glow_step_ms_q <= pwdata[7:0];
				REG_IDLE_POLL_MS: idle_poll_ms_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Handshake: the input stage moves on whenever the result register can take its step.
	assign adv          = valid_s1 && (!res_valid_q || led.ready);
	assign sample.ready = !valid_s1 || adv;
	assign led.valid    = res_valid_q;
	assign led.data     = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (sample.ready) begin
				valid_s1 <= sample.valid;
			end
			if (adv) begin
				res_valid_q <= 1'b1;
			end else if (led.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			data_s1 <= sample.data;
		end
		if (adv) begin
			res_q.red     <= red_d;
			res_q.green   <= green_d;
			res_q.blue    <= blue_d;
			res_q.stepped <= expired;
		end
	end

	// Timer check on the wrapped time difference.
	assign now_ext = CW'(data_s1.now_ms);
	assign now_tb  = now_ext[TIME_BITS-1:0];
	assign elapsed = now_tb - last_q;
	assign expired = CW'(elapsed) >= CW'(wait_q);

	// Random values scaled as min + ((r * span) >> bits).
	assign prod_level = 16'(data_s1.rand_level) * 16'(FLICK_SPAN);
	assign prod_delay = 16'(data_s1.rand_delay) * 16'(DELAY_SPAN);
	assign prod_count = 16'(data_s1.rand_delay) * 16'(COUNT_SPAN);
	assign prod_pause = 28'(data_s1.rand_pause) * 28'(PAUSE_SPAN);
	assign flick_lvl  = 8'(FLICK_MIN) + prod_level[15:8];
	assign white_lvl  = (flick_lvl > 8'(SUB_BLUE)) ? flick_lvl - 8'(SUB_BLUE) : 8'd0;
	assign delay_ms   = 8'(DELAY_MIN) + prod_delay[15:8];
	assign count_val  = 8'(COUNT_MIN) + prod_count[15:8];
	assign pause_ms   = 16'(PAUSE_MIN) + 16'(prod_pause[27:16]);
	assign flick_dec  = flickers_q - 8'd1;
	assign green_dec  = green_q - 8'd1;

	always_comb begin
		wait_d     = wait_q;
		flickers_d = flickers_q;
		red_d      = red_q;
		green_d    = green_q;
		blue_d     = blue_q;
		if (expired) begin
			if (flickers_q != 8'd0) begin
				if (flick_dec == 8'd0 || !data_s1.enable) begin
					// Arc ends: switch to the yellow afterglow.
					red_d      = {glow_start_q, 2'b00};
					green_d    = {2'b00, glow_start_q};
					blue_d     = 8'd0;
					wait_d     = 16'(glow_step_ms_q);
					flickers_d = 8'd0;
				end else begin
					red_d      = white_lvl;
					green_d    = white_lvl;
					blue_d     = flick_lvl;
					wait_d     = 16'(delay_ms);
					flickers_d = flick_dec;
				end
			end else if (green_q != 8'd0) begin
				green_d = green_dec;
				red_d   = {green_dec[5:0], 2'b00};
				if (green_dec == 8'd0) begin
					wait_d = pause_ms;
				end
			end else if (data_s1.enable) begin
				flickers_d = count_val;
			end else begin
				wait_d = 16'(idle_poll_ms_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q     <= '0;
			wait_q     <= '0;
			flickers_q <= '0;
			red_q      <= '0;
			green_q    <= '0;
			blue_q     <= '0;
		end else if (adv) begin
			if (expired) begin
				last_q <= now_tb;
			end
			wait_q     <= wait_d;
			flickers_q <= flickers_d;
			red_q      <= red_d;
			green_q    <= green_d;
			blue_q     <= blue_d;
		end
	end

endmodule

// File: rtl/core/wle_checker.sv
// Port-level checker for the welding light effect, bound to the top level.
`timescale 1ns / 1ps

module wle_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue,
	input logic       stepped
);
	logic [1:0] pend_q;
	logic [7:0] red_q;
	logic [7:0] green_q;
	logic [7:0] blue_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Transactions taken in but not yet delivered, and the colors last delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= 2'd0;
			red_q   <= 8'd0;
			green_q <= 8'd0;
			blue_q  <= 8'd0;
		end else begin
			pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
			if (out_acc) begin
				red_q   <= red;
				green_q <= green;
				blue_q  <= blue;
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable({red, green, blue, stepped}))
		else $error("result payload changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 2'd0 |-> !out_valid)
		else $error("result shown with no transaction pending");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 2'd2 && !out_ready |-> !in_ready)
		else $error("input taken while both stages are full");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !stepped |-> red == red_q && green == green_q && blue == blue_q)
		else $error("LED changed on a call that took no step");

endmodule

bind welding_light_effect wle_checker u_wle_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.out_valid (led.valid),
	.out_ready (led.ready),
	.red       (led.data.red),
	.green     (led.data.green),
	.blue      (led.data.blue),
	.stepped   (led.data.stepped)
);
